// ===== design/rank_by_distance_and_clamp_defines.svh =====
// ----------------------------------------------------------------------------
// rank_by_distance_and_clamp assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef RANK_BY_DISTANCE_AND_CLAMP_DEFINES_SVH
`define RANK_BY_DISTANCE_AND_CLAMP_DEFINES_SVH

// same-cycle implication, off during reset
`define RBD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rbd: same-cycle check failed");

// next-cycle implication, active during reset too
`define RBD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("rbd: next-cycle check failed");

`endif

// ===== design/rbd_pkg.sv =====
// ----------------------------------------------------------------------------
// rbd_pkg
// shared constants and controller/datapath interface types
// ----------------------------------------------------------------------------
package rbd_pkg;

  localparam int DefMaxItems  = 32;
  localparam int ResultLimit  = 32;
  localparam int CoordW       = 32;
  localparam int KeyW         = 32;
  localparam int DistW        = 64;
  localparam int LoadIdxW     = 5;
  localparam int KeptW        = 6;
  localparam int CfgIdxW      = 8;
  localparam int InDataW      = 224;
  localparam int OutDataW     = 48;

  localparam logic [CfgIdxW-1:0] REG_VIEW_X   = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_VIEW_Y   = 8'd1;
  localparam logic [CfgIdxW-1:0] REG_VIEW_Z   = 8'd2;
  localparam logic [CfgIdxW-1:0] REG_MAX_KEPT = 8'd3;

  localparam logic [KeptW-1:0] MaxKeptReset = 6'd32;

  typedef struct packed {
    logic capture;
    logic insert;
    logic setup;
    logic emit;
    logic clear_set;
    logic set_ovf;
  } rbd_cmd_t;

  typedef struct packed {
    logic full;
    logic out_free;
    logic last_rank;
  } rbd_stat_t;

endpackage

// ===== design/rbd_dist.sv =====
// ----------------------------------------------------------------------------
// rbd_dist
// squared distance pipeline: center/offset, square, saturating sum
// ----------------------------------------------------------------------------
module rbd_dist (
  input  logic                              clk,
  input  logic                              capture,
  input  logic signed [rbd_pkg::CoordW-1:0] min_x,
  input  logic signed [rbd_pkg::CoordW-1:0] max_x,
  input  logic signed [rbd_pkg::CoordW-1:0] min_y,
  input  logic signed [rbd_pkg::CoordW-1:0] max_y,
  input  logic signed [rbd_pkg::CoordW-1:0] min_z,
  input  logic signed [rbd_pkg::CoordW-1:0] max_z,
  input  logic signed [rbd_pkg::CoordW-1:0] view_x,
  input  logic signed [rbd_pkg::CoordW-1:0] view_y,
  input  logic signed [rbd_pkg::CoordW-1:0] view_z,
  output logic        [rbd_pkg::DistW-1:0]  dist_sq
);
  import rbd_pkg::*;

  logic signed [CoordW-1:0] lo [3];
  logic signed [CoordW-1:0] hi [3];
  logic signed [CoordW-1:0] vw [3];
  logic        [CoordW-1:0] mag [3];
  logic        [DistW-1:0]  sq [3];
  logic        [CoordW-1:0] mag_next [3];
  logic        [DistW:0]    sum_a;
  logic        [DistW-1:0]  sat_a;
  logic        [DistW:0]    sum_b;

  assign vw[0] = view_x;
  assign vw[1] = view_y;
  assign vw[2] = view_z;

  always_ff @(posedge clk) begin
    if (capture) begin
      lo[0] <= min_x;  hi[0] <= max_x;
      lo[1] <= min_y;  hi[1] <= max_y;
      lo[2] <= min_z;  hi[2] <= max_z;
    end
  end

  // center rounds toward minus infinity; |offset| never exceeds 2^32-1
  always_comb begin
    logic signed [CoordW:0]   csum;
    logic signed [CoordW+1:0] off;
    for (int a = 0; a < 3; a++) begin
      csum = {lo[a][CoordW-1], lo[a]} + {hi[a][CoordW-1], hi[a]};
      off  = {{2{csum[CoordW]}}, csum[CoordW:1]} - {{2{vw[a][CoordW-1]}}, vw[a]};
      mag_next[a] = off[CoordW+1] ? CoordW'(-off) : off[CoordW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      mag[a] <= mag_next[a];
      sq[a]  <= DistW'(mag[a]) * DistW'(mag[a]);
    end
  end

  assign sum_a = {1'b0, sq[0]} + {1'b0, sq[1]};
  assign sat_a = sum_a[DistW] ? {DistW{1'b1}} : sum_a[DistW-1:0];
  assign sum_b = {1'b0, sat_a} + {1'b0, sq[2]};

  always_ff @(posedge clk) begin
    dist_sq <= sum_b[DistW] ? {DistW{1'b1}} : sum_b[DistW-1:0];
  end

endmodule

// ===== design/rbd_dp.sv =====
// ----------------------------------------------------------------------------
// rbd_dp
// datapath: config registers, distance unit, insertion chain, result register
// ----------------------------------------------------------------------------
module rbd_dp #(
  parameter int MAX_ITEMS = rbd_pkg::DefMaxItems
) (
  input  logic                               clk,
  input  logic                               rst,
  input  rbd_pkg::rbd_cmd_t                  cmd,
  output rbd_pkg::rbd_stat_t                 stat,
  input  logic                               cfg_valid,
  input  logic [rbd_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [rbd_pkg::CoordW-1:0]         cfg_data,
  input  logic [rbd_pkg::InDataW-1:0]        s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [rbd_pkg::OutDataW-1:0]       m_tdata,
  output logic                               m_tlast
);
  import rbd_pkg::*;

  localparam int CntW = $clog2(MAX_ITEMS + 1);

  logic signed [CoordW-1:0] view_x, view_y, view_z;
  logic [KeptW-1:0]  max_kept;
  logic [DistW-1:0]  dist_sq;
  logic [KeyW-1:0]   key;
  logic [CntW-1:0]   count;
  logic              overflow_seen;
  logic [KeptW-1:0]  remaining;
  logic              none_kept;
  logic [KeptW-1:0]  dropped;

  logic [DistW-1:0]    cell_dist [MAX_ITEMS];
  logic [KeyW-1:0]     cell_key  [MAX_ITEMS];
  logic [LoadIdxW-1:0] cell_idx  [MAX_ITEMS];
  logic [MAX_ITEMS-1:0] ahead;

  logic [7:0] cnt8, mk8, em8;

  always_ff @(posedge clk) begin
    if (rst) begin
      view_x   <= '0;
      view_y   <= '0;
      view_z   <= '0;
      max_kept <= MaxKeptReset;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_VIEW_X:   view_x   <= cfg_data;
        REG_VIEW_Y:   view_y   <= cfg_data;
        REG_VIEW_Z:   view_z   <= cfg_data;
        REG_MAX_KEPT: max_kept <= cfg_data[KeptW-1:0];
        default: ;
      endcase
    end
  end

  rbd_dist u_dist (
    .clk     (clk),
    .capture (cmd.capture),
    .min_x   (s_tdata[0*CoordW +: CoordW]),
    .max_x   (s_tdata[1*CoordW +: CoordW]),
    .min_y   (s_tdata[2*CoordW +: CoordW]),
    .max_y   (s_tdata[3*CoordW +: CoordW]),
    .min_z   (s_tdata[4*CoordW +: CoordW]),
    .max_z   (s_tdata[5*CoordW +: CoordW]),
    .view_x  (view_x),
    .view_y  (view_y),
    .view_z  (view_z),
    .dist_sq (dist_sq)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) key <= s_tdata[6*CoordW +: KeyW];
  end

  // cells compare with the new entry; ties in distance go by key, then by load order
  always_comb begin
    for (int i = 0; i < MAX_ITEMS; i++) begin
      ahead[i] = (CntW'(i) < count) &&
                 ((dist_sq < cell_dist[i]) ||
                  (dist_sq == cell_dist[i] && key < cell_key[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      for (int i = 0; i < MAX_ITEMS; i++) begin
        if (i > 0 && ahead[(i > 0) ? i - 1 : 0]) begin
          cell_dist[i] <= cell_dist[(i > 0) ? i - 1 : 0];
          cell_key[i]  <= cell_key[(i > 0) ? i - 1 : 0];
          cell_idx[i]  <= cell_idx[(i > 0) ? i - 1 : 0];
        end else if (ahead[i] || CntW'(i) == count) begin
          cell_dist[i] <= dist_sq;
          cell_key[i]  <= key;
          cell_idx[i]  <= count[LoadIdxW-1:0];
        end
      end
    end else if (cmd.emit) begin
      for (int i = 0; i < MAX_ITEMS - 1; i++) begin
        cell_dist[i] <= cell_dist[i+1];
        cell_key[i]  <= cell_key[i+1];
        cell_idx[i]  <= cell_idx[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_set) begin
      count         <= '0;
      overflow_seen <= 1'b0;
    end else begin
      if (cmd.insert)  count <= count + 1'b1;
      if (cmd.set_ovf) overflow_seen <= 1'b1;
    end
  end

  // emitted = min(count, max_kept, result limit)
  assign cnt8 = 8'(count);
  assign mk8  = 8'(max_kept);
  always_comb begin
    em8 = (cnt8 < mk8) ? cnt8 : mk8;
    if (em8 > 8'(ResultLimit)) em8 = 8'(ResultLimit);
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      remaining <= em8[KeptW-1:0];
      none_kept <= (em8 == 8'd0);
      dropped   <= (cnt8 > mk8) ? KeptW'(cnt8 - mk8) : '0;
    end else if (cmd.emit) begin
      remaining <= remaining - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= {3'b000, overflow_seen, dropped, ~none_kept,
                  none_kept ? {LoadIdxW{1'b0}} : cell_idx[0],
                  none_kept ? {KeyW{1'b0}} : cell_key[0]};
      m_tlast <= none_kept || remaining == KeptW'(1);
    end
  end

  assign stat.full      = (count == CntW'(MAX_ITEMS));
  assign stat.out_free  = !m_tvalid || m_tready;
  assign stat.last_rank = none_kept || remaining == KeptW'(1);

endmodule

// ===== design/rbd_ctrl.sv =====
// ----------------------------------------------------------------------------
// rbd_ctrl
// sequencer: accept, wait on distance pipeline, insert, emit ranked run
// ----------------------------------------------------------------------------
module rbd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic               s_tlast,
  input  rbd_pkg::rbd_stat_t stat,
  output rbd_pkg::rbd_cmd_t  cmd
);
  import rbd_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CALC   = 3'd1;
  localparam logic [2:0] ST_INSERT = 3'd2;
  localparam logic [2:0] ST_SETUP  = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;

  localparam logic [1:0] CalcLast = 2'd2;

  logic [2:0] state, state_next;
  logic [1:0] wait_cnt;
  logic       pend_last;
  logic       take;

  assign s_tready = (state == ST_IDLE);
  assign take     = s_tvalid && s_tready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (take) begin
          if (stat.full) begin
            cmd.set_ovf = 1'b1;
            if (s_tlast) state_next = ST_SETUP;
          end else begin
            cmd.capture = 1'b1;
            state_next  = ST_CALC;
          end
        end
      end
      ST_CALC: begin
        if (wait_cnt == CalcLast) state_next = ST_INSERT;
      end
      ST_INSERT: begin
        cmd.insert = 1'b1;
        state_next = pend_last ? ST_SETUP : ST_IDLE;
      end
      ST_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.last_rank) begin
            cmd.clear_set = 1'b1;
            state_next    = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      wait_cnt  <= '0;
      pend_last <= 1'b0;
    end else begin
      state <= state_next;
      if (take) pend_last <= s_tlast;
      wait_cnt <= (state == ST_CALC) ? wait_cnt + 1'b1 : '0;
    end
  end

endmodule

// ===== design/rank_by_distance_and_clamp.sv =====
// ----------------------------------------------------------------------------
// rank_by_distance_and_clamp
// nearest-first ranking of a set of boxes with a kept-count clamp
// ----------------------------------------------------------------------------
// Each box transaction is accepted, passes the distance pipeline
// (center/offset, 32x32 squares, saturating sum) and is inserted into the sorted
// cell chain, where every cell compares itself with the new entry in parallel.
// An item arriving when MAX_ITEMS entries are held is ignored and raises
// overflow. After the item with tlast, a setup step follows, then one result
// per cycle while the output is drained; the input is held off through the
// setup and the whole run, including any output stall. The output register
// lets the final result wait while the next set begins loading.
// Configuration writes are always taken (cfg_ready stays high).
module rank_by_distance_and_clamp #(
  parameter int MAX_ITEMS = rbd_pkg::DefMaxItems
) (
  input  logic                         clk,
  input  logic                         rst,
  // config write channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [rbd_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [rbd_pkg::CoordW-1:0]   cfg_data,
  // box input
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // min_x, max_x, min_y, max_y, min_z, max_z, item_key (32 bits each)
  input  logic [rbd_pkg::InDataW-1:0]  s_tdata,
  input  logic                         s_tlast,   // set_end
  // ranked output
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // kept_key[31:0], load_index[36:32], entry_valid[37], dropped_count[43:38],
  // overflow[44], zero pad[47:45]
  output logic [rbd_pkg::OutDataW-1:0] m_tdata,
  output logic                         m_tlast    // run_end
);
  import rbd_pkg::*;

  rbd_cmd_t  cmd;
  rbd_stat_t stat;

  assign cfg_ready = 1'b1;

  // sequencer
  rbd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .stat     (stat),
    .cmd      (cmd)
  );

  // registers, distance unit, sorted chain and result register
  rbd_dp #(.MAX_ITEMS(MAX_ITEMS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

// ===== design/rbd_checker.sv =====
// ----------------------------------------------------------------------------
// rbd_checker
// port-level checks on the ranked output stream
// ----------------------------------------------------------------------------
`include "rank_by_distance_and_clamp_defines.svh"

module rbd_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tready,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [rbd_pkg::OutDataW-1:0] m_tdata,
  input logic                         m_tlast
);

  // nothing leaves right after reset
  `RBD_ASSERT_NXT(a_reset_quiet, rst, !m_tvalid)
  // an empty-run marker is always the whole run
  `RBD_ASSERT_IMP(a_empty_is_last, m_tvalid && !m_tdata[37], m_tlast)
  // mid-run results only appear while input is held off
  `RBD_ASSERT_IMP(a_run_blocks_in, m_tvalid && !m_tlast, !s_tready)
  // a stalled result stays put
  `RBD_ASSERT_IMP(a_hold_stall, $past(m_tvalid && !m_tready) && !$past(rst), m_tvalid && $stable(m_tdata) && $stable(m_tlast))

endmodule

bind rank_by_distance_and_clamp rbd_checker u_rbd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
